// ----- hw/rtl/slid_pkg.sv -----
// Package for the sorted insertion list: payload structs, command and status
// codes, and the control and status structs between controller and datapath.
// No dependencies.
package slid_pkg;

  // Default sizes of the list.
  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the two channels.
  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // Read address choices, relative to the datapath pointer.
  localparam logic [2:0] RA_PTR    = 3'd0;
  localparam logic [2:0] RA_PTR_M1 = 3'd1;
  localparam logic [2:0] RA_PTR_M2 = 3'd2;
  localparam logic [2:0] RA_PTR_P1 = 3'd3;
  localparam logic [2:0] RA_PTR_P2 = 3'd4;

  // Write data choices.
  localparam logic WS_VALUE = 1'b0;
  localparam logic WS_RDATA = 1'b1;

  // One request item.
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] data;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       latch_status;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       occ_inc;
    logic       occ_dec;
    logic       cap_data;
    logic       load_rsp;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic is_read;
    logic fault;
    logic ptr_zero;
    logic ptr_one;
    logic ge;
    logic del_last;
    logic move_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/slid_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/slid_dp.sv -----
// Datapath of the sorted insertion list: request and pointer registers, the
// occupancy count, the entry RAM and the result register.
// Depends on slid_pkg and slid_ram.
module slid_dp #(
  parameter int DEPTH       = slid_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  slid_pkg::req_t    req_in,
  input  slid_pkg::dp_cmd_t ctl,
  output slid_pkg::dp_stat_t stat,
  output slid_pkg::rsp_t    rsp_out
);

  localparam int SW  = (VALUE_WIDTH < slid_pkg::VAL_W) ? VALUE_WIDTH : slid_pkg::VAL_W;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW  = $clog2(DEPTH + 1);
  localparam int IW  = slid_pkg::IDX_W;
  localparam int CW  = (OW > IW) ? OW : IW;
  localparam int DW  = slid_pkg::VAL_W;
  localparam int NW  = slid_pkg::CNT_W;

  logic [OW-1:0]             occ;
  logic [slid_pkg::CMD_W-1:0] command;
  logic signed [SW-1:0]      value;
  logic [IW-1:0]             index;
  logic [OW-1:0]             ptr;
  logic [slid_pkg::ST_W-1:0] status_q;
  logic signed [DW-1:0]      data_q;
  slid_pkg::rsp_t            rsp_q;

  logic [slid_pkg::ST_W-1:0] pre_status;
  logic [OW-1:0]             raddr_full;
  logic [AW-1:0]             ram_raddr;
  logic [SW-1:0]             ram_wdata;
  logic [SW-1:0]             ram_rdata;
  logic signed [SW-1:0]      rdata_s;
  logic [OW:0]               ptr_p1;
  logic [OW:0]               ptr_p2;

  assign rdata_s = ram_rdata;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctl.occ_inc) begin
      occ <= occ + 1'b1;
    end else if (ctl.occ_dec) begin
      occ <= occ - 1'b1;
    end
  end

  // Request registers and the working pointer.
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      command <= req_in.command;
      value   <= req_in.value[SW-1:0];
      index   <= req_in.index;
      if (req_in.command == slid_pkg::CMD_INSERT) begin
        ptr <= occ;
      end else begin
        ptr <= OW'(req_in.index);
      end
    end else if (ctl.ptr_dec) begin
      ptr <= ptr - 1'b1;
    end else if (ctl.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Status of the item, decided before any entry moves.
  always_comb begin
    if (command == slid_pkg::CMD_INSERT) begin
      pre_status = (occ >= OW'(DEPTH)) ? slid_pkg::ST_FULL : slid_pkg::ST_OK;
    end else if (command != slid_pkg::CMD_READ && command != slid_pkg::CMD_DELETE) begin
      pre_status = slid_pkg::ST_RANGE;
    end else if (occ == '0) begin
      pre_status = slid_pkg::ST_EMPTY;
    end else if (CW'(index) >= CW'(occ)) begin
      pre_status = slid_pkg::ST_RANGE;
    end else begin
      pre_status = slid_pkg::ST_OK;
    end
  end

  // Result status and data.
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      data_q <= '0;
    end else if (ctl.cap_data) begin
      data_q <= DW'(rdata_s);
    end
    if (ctl.latch_status) begin
      status_q <= pre_status;
    end
  end

  // Read address relative to the pointer.
  always_comb begin
    case (ctl.rd_sel)
      slid_pkg::RA_PTR:    raddr_full = ptr;
      slid_pkg::RA_PTR_M1: raddr_full = ptr - OW'(1);
      slid_pkg::RA_PTR_M2: raddr_full = ptr - OW'(2);
      slid_pkg::RA_PTR_P1: raddr_full = ptr + OW'(1);
      slid_pkg::RA_PTR_P2: raddr_full = ptr + OW'(2);
      default:             raddr_full = ptr;
    endcase
  end

  assign ram_raddr = raddr_full[AW-1:0];
  assign ram_wdata = (ctl.wr_sel == slid_pkg::WS_RDATA) ? ram_rdata : value;

  slid_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ptr[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status towards the controller.
  assign ptr_p1 = (OW + 1)'(ptr) + (OW + 1)'(1);
  assign ptr_p2 = (OW + 1)'(ptr) + (OW + 1)'(2);

  always_comb begin
    stat.is_insert = (command == slid_pkg::CMD_INSERT);
    stat.is_read   = (command == slid_pkg::CMD_READ);
    stat.fault     = (pre_status != slid_pkg::ST_OK);
    stat.ptr_zero  = (ptr == '0);
    stat.ptr_one   = (ptr == OW'(1));
    stat.ge        = (rdata_s >= value);
    stat.del_last  = (ptr_p1 >= (OW + 1)'(occ));
    stat.move_last = (ptr_p2 >= (OW + 1)'(occ));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.load_rsp) begin
      rsp_q.status <= status_q;
      rsp_q.data   <= data_q;
      rsp_q.count  <= NW'(occ);
    end
  end

  assign rsp_out = rsp_q;

endmodule

// ----- hw/rtl/slid_ctrl.sv -----
// Controller of the sorted insertion list: the state machine that sequences
// checks, RAM reads and shifts, and owns both handshakes. Depends on slid_pkg.
module slid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  slid_pkg::dp_stat_t stat,
  output slid_pkg::dp_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_INS_CMP   = 3'd2;
  localparam logic [2:0] S_INS_PLACE = 3'd3;
  localparam logic [2:0] S_RD_WAIT   = 3'd4;
  localparam logic [2:0] S_DEL_MOVE  = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // No item is taken while reset is held.
  assign cmd_ready = (state == S_IDLE) && !rst;

  // Next state and datapath commands.
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          ctl.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.latch_status = 1'b1;
        if (stat.fault) begin
          state_next = S_FINISH;
        end else if (stat.is_insert) begin
          if (stat.ptr_zero) begin
            state_next = S_INS_PLACE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = slid_pkg::RA_PTR_M1;
            state_next = S_INS_CMP;
          end
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = slid_pkg::RA_PTR;
          state_next = S_RD_WAIT;
        end
      end
      S_INS_CMP: begin
        // Move larger or equal entries up by one until the gap is found.
        ctl.wr_en = 1'b1;
        if (stat.ge) begin
          ctl.wr_sel  = slid_pkg::WS_RDATA;
          ctl.ptr_dec = 1'b1;
          if (stat.ptr_one) begin
            state_next = S_INS_PLACE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = slid_pkg::RA_PTR_M2;
          end
        end else begin
          ctl.wr_sel  = slid_pkg::WS_VALUE;
          ctl.occ_inc = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_INS_PLACE: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = slid_pkg::WS_VALUE;
        ctl.occ_inc = 1'b1;
        state_next  = S_FINISH;
      end
      S_RD_WAIT: begin
        ctl.cap_data = 1'b1;
        if (stat.is_read) begin
          state_next = S_FINISH;
        end else if (stat.del_last) begin
          ctl.occ_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = slid_pkg::RA_PTR_P1;
          state_next = S_DEL_MOVE;
        end
      end
      S_DEL_MOVE: begin
        // Move each later entry down by one to close the gap.
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = slid_pkg::WS_RDATA;
        ctl.ptr_inc = 1'b1;
        if (stat.move_last) begin
          ctl.occ_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = slid_pkg::RA_PTR_P2;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/sorted_list_insert_index_delete.sv -----
// Top level of the sorted insertion list: joins the controller and the
// datapath. Depends on slid_pkg, slid_ctrl and slid_dp.
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_ready  slid_pkg::req_t (command, value, index)
//   rsp      out  rsp_valid / rsp_ready  slid_pkg::rsp_t (status, data, count)
//
// A request that ends in an error and a read move no entry; an insert moves
// each stored value that is greater or equal up by one, and a delete moves
// each entry after the index down by one.
// The shifting is set by the entry RAM: one entry moves per cycle through its
// single write port. The result register lets the next item be accepted while
// a result waits; a new result waits in its last state if the previous one is
// still held. Reset clears the count and the handshakes; the RAM is not cleared.
module sorted_list_insert_index_delete #(
  parameter int DEPTH       = slid_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = slid_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  slid_pkg::req_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output slid_pkg::rsp_t rsp
);

  slid_pkg::dp_cmd_t  ctl;
  slid_pkg::dp_stat_t stat;

  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  slid_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .req_in  (cmd),
    .ctl     (ctl),
    .stat    (stat),
    .rsp_out (rsp)
  );

endmodule

// ----- hw/rtl/slid_checker.sv -----
// Port-level checks for the sorted insertion list, bound to the top level.
// Depends on slid_pkg and sorted_list_insert_index_delete.
module slid_checker #(
  parameter int DEPTH = slid_pkg::DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input slid_pkg::req_t cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input slid_pkg::rsp_t rsp
);

  localparam int NW = slid_pkg::CNT_W;

  // A waiting item keeps its payload until taken.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("item changed while waiting");

  // A held result keeps its value until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Items are taken one at a time: no acceptance right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while the previous one was still in work");

  // Any failed item carries zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != slid_pkg::ST_OK |-> rsp.data == '0)
    else $error("failed item returned non-zero data");

  // Empty and full reports agree with the count.
  a_count_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == slid_pkg::ST_EMPTY || rsp.status == slid_pkg::ST_FULL) |->
    (rsp.status == slid_pkg::ST_EMPTY && rsp.count == '0) ||
    (rsp.status == slid_pkg::ST_FULL && rsp.count == NW'(DEPTH)))
    else $error("status code disagrees with count");

endmodule

bind sorted_list_insert_index_delete slid_checker #(
  .DEPTH (DEPTH)
) u_slid_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for sorted_list_insert_index_delete: random and directed
// insert, read, delete and unused-command items against an in-bench list predictor.
// Depends on slid_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIST_DEPTH     = slid_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1030;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 3000;

  // Command 3 has no operation behind it.
  localparam logic [slid_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [slid_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [slid_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  slid_pkg::req_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  slid_pkg::rsp_t rsp;

  // Items waiting to be driven, and results still owed by the block.
  slid_pkg::req_t req_backlog[$];
  slid_pkg::rsp_t due_results[$];

  // Predicted contents of the list.
  logic signed [slid_pkg::VAL_W-1:0] sorted_vals [LIST_DEPTH];
  int stored_count = 0;

  // Rough occupancy used only to steer indices during generation.
  int steer_count = 0;

  int   error_count = 0;
  int   quiet_cycles = 0;
  logic cmd_taken = 1'b0;

  sorted_list_insert_index_delete i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one accepted item to the predicted list and give its result.
  task automatic apply_list_op(input slid_pkg::req_t r, output slid_pkg::rsp_t res);
    int pos;
    int idx;
    logic signed [slid_pkg::VAL_W-1:0] v;
    res = '0;
    v = r.value;
    idx = int'(r.index);
    case (r.command)
      slid_pkg::CMD_INSERT: begin
        if (stored_count >= LIST_DEPTH) begin
          res.status = slid_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < stored_count && sorted_vals[pos] < v) pos++;
          for (int i = stored_count; i > pos; i--) sorted_vals[i] = sorted_vals[i - 1];
          sorted_vals[pos] = v;
          stored_count++;
          res.status = slid_pkg::ST_OK;
        end
      end
      slid_pkg::CMD_READ, slid_pkg::CMD_DELETE: begin
        if (stored_count == 0) begin
          res.status = slid_pkg::ST_EMPTY;
        end else if (idx >= stored_count) begin
          res.status = slid_pkg::ST_RANGE;
        end else begin
          res.status = slid_pkg::ST_OK;
          res.data   = sorted_vals[idx];
          if (r.command == slid_pkg::CMD_DELETE) begin
            for (int i = idx; i + 1 < stored_count; i++) sorted_vals[i] = sorted_vals[i + 1];
            stored_count--;
          end
        end
      end
      default: begin
        res.status = slid_pkg::ST_RANGE;
      end
    endcase
    res.count = slid_pkg::CNT_W'(stored_count);
  endtask

  // Queue one item and track roughly how full the list will be.
  task automatic queue_item(input logic [slid_pkg::CMD_W-1:0] c,
                            input logic signed [slid_pkg::VAL_W-1:0] v,
                            input logic [slid_pkg::IDX_W-1:0] idx);
    slid_pkg::req_t r;
    r.command = c;
    r.value   = v;
    r.index   = idx;
    req_backlog.push_back(r);
    if (c == slid_pkg::CMD_INSERT && steer_count < LIST_DEPTH) begin
      steer_count++;
    end else if (c == slid_pkg::CMD_DELETE && int'(idx) < steer_count) begin
      steer_count--;
    end
  endtask

  // Values lean towards a narrow band so that duplicates are common.
  function automatic logic signed [slid_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  // Indices are mostly in range, sometimes just past the end, sometimes anywhere.
  function automatic logic [slid_pkg::IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0 || steer_count == 0) return slid_pkg::IDX_W'($urandom_range(0, 1023));
    if (r == 1) return slid_pkg::IDX_W'(steer_count + $urandom_range(0, 1));
    return slid_pkg::IDX_W'($urandom_range(0, steer_count - 1));
  endfunction

  // Build the stimulus, release reset and wait for the block to drain.
  initial begin
    phase_t phase;
    int     len;
    int     roll;
    int     ins_pct;
    int     rd_pct;
    int     del_pct;
    int     rand_items;

    // Directed part: empty list, unused command, extremes, duplicates, boundaries.
    queue_item(slid_pkg::CMD_READ, 0, 0);
    queue_item(slid_pkg::CMD_DELETE, 0, 10'd1023);
    queue_item(CMD_UNUSED, VAL_MAX, 10'd1023);
    queue_item(slid_pkg::CMD_INSERT, 5, 0);
    queue_item(slid_pkg::CMD_DELETE, 0, 0);
    queue_item(slid_pkg::CMD_INSERT, VAL_MAX, 0);
    queue_item(slid_pkg::CMD_INSERT, VAL_MIN, 0);
    queue_item(slid_pkg::CMD_INSERT, 0, 0);
    queue_item(slid_pkg::CMD_INSERT, 0, 0);
    queue_item(slid_pkg::CMD_INSERT, -1, 0);
    queue_item(slid_pkg::CMD_READ, 0, 0);
    queue_item(slid_pkg::CMD_READ, 0, 4);
    queue_item(slid_pkg::CMD_READ, 0, 5);
    queue_item(slid_pkg::CMD_READ, 0, 10'd1023);
    queue_item(slid_pkg::CMD_DELETE, 0, 2);
    queue_item(slid_pkg::CMD_DELETE, 0, 3);
    queue_item(slid_pkg::CMD_DELETE, 0, 4);
    queue_item(slid_pkg::CMD_DELETE, 0, 0);
    queue_item(slid_pkg::CMD_READ, 0, 1);
    queue_item(CMD_UNUSED, VAL_MIN, 0);

    // Random part: phases that fill, drain or churn the list.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase = phase_t'($urandom_range(0, 2));
      len   = $urandom_range(40, 150);
      if (len > RANDOM_ITEMS - rand_items) begin
        len = RANDOM_ITEMS - rand_items;
      end
      case (phase)
        PHASE_FILL: begin
          ins_pct = 80; rd_pct = 10; del_pct = 8;
        end
        PHASE_DRAIN: begin
          ins_pct = 20; rd_pct = 15; del_pct = 63;
        end
        default: begin
          ins_pct = 40; rd_pct = 30; del_pct = 27;
        end
      endcase
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          queue_item(slid_pkg::CMD_INSERT, pick_value(),
                     slid_pkg::IDX_W'($urandom_range(0, 1023)));
        end else if (roll < ins_pct + rd_pct) begin
          queue_item(slid_pkg::CMD_READ, $urandom, pick_index());
        end else if (roll < ins_pct + rd_pct + del_pct) begin
          queue_item(slid_pkg::CMD_DELETE, $urandom, pick_index());
        end else begin
          queue_item(CMD_UNUSED, $urandom, slid_pkg::IDX_W'($urandom_range(0, 1023)));
        end
        rand_items++;
      end
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() > 0 || cmd_valid || due_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Request driver: bursts of items separated by random gaps.
  int burst_left = 1;
  int idle_gap = 0;

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (idle_gap > 0) begin
        cmd_valid <= 1'b0;
        idle_gap = idle_gap - 1;
      end else if (req_backlog.size() > 0) begin
        cmd       <= req_backlog.pop_front();
        cmd_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result receiver: runs of ready, runs of stall, and runs of coin flips.
  int ready_mode = 0;
  int ready_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        case (ready_mode)
          0, 3: ready_left = $urandom_range(1, 40);
          1: ready_left = $urandom_range(1, 12);
          default: ready_left = $urandom_range(4, 30);
        endcase
      end
      ready_left = ready_left - 1;
      case (ready_mode)
        1: rsp_ready <= 1'b0;
        2: rsp_ready <= 1'($urandom_range(0, 1));
        default: rsp_ready <= 1'b1;
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    slid_pkg::rsp_t predicted;
    slid_pkg::rsp_t owed;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_valid && cmd_ready;
      if (cmd_valid && cmd_ready) begin
        apply_list_op(cmd, predicted);
        due_results.push_back(predicted);
      end
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%0d count=%0d",
                   $time, rsp.status, rsp.data, rsp.count);
          error_count++;
        end else begin
          owed = due_results.pop_front();
          if (rsp.status !== owed.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, owed.status, rsp.status);
            error_count++;
          end
          if (rsp.data !== owed.data) begin
            $display("%0t: data mismatch, expected %0d, actual %0d",
                     $time, owed.data, rsp.data);
            error_count++;
          end
          if (rsp.count !== owed.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, owed.count, rsp.count);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no handshake for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/slid_pkg.sv
hw/rtl/slid_ram.sv
hw/rtl/slid_dp.sv
hw/rtl/slid_ctrl.sv
hw/rtl/sorted_list_insert_index_delete.sv
hw/rtl/slid_checker.sv
tb/tb_top.sv
